### hw/rtl/tsae_pkg.sv
// Shared types and constants for the track speed and acceleration estimator.
package tsae_pkg;

    localparam int POS_W = 18;
    localparam int VEL_W = 21;
    localparam int ACC_W = 25;

    localparam logic [17:0] PITCH_LEN_RST = 18'd105000;
    localparam logic [17:0] PITCH_WID_RST = 18'd68000;
    localparam logic [23:0] INV_TWO_DT_RST = 24'd163840;
    localparam logic [27:0] INV_DT_SQ_RST = 28'd1638400;

    localparam logic [1:0] REG_PITCH_LEN = 2'd0;
    localparam logic [1:0] REG_PITCH_WID = 2'd1;
    localparam logic [1:0] REG_INV_TWO_DT = 2'd2;
    localparam logic [1:0] REG_INV_DT_SQ = 2'd3;

    // sequencer phases
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POSX,
        ST_POSY,
        ST_VX,
        ST_VY,
        ST_AX,
        ST_AY,
        ST_SPD,
        ST_AMAG,
        ST_OUT
    } state_t;

    // serial multiply unit: one multiplier bit per cycle
    localparam int MUL_CYC = 28;
    // isqrt: one result bit per cycle over a 52-bit radicand
    localparam int SQRT_CYC = 26;

endpackage

### hw/rtl/track_speed_accel_estimator.sv
// Top level: track position samples in, centred-difference velocity and acceleration out.
//
// Input stream s_axis: one transaction per normalized x,y position sample.
// Output stream m_axis: one result transaction per sample from the third
// sample on; the first two samples only fill the position history.
// A shift-and-add multiplier takes one multiplier bit per cycle and a
// restoring square root takes one root bit per cycle; the sequencer runs
// the two positions, four scaled differences and two magnitudes through them.
// Each phase loads its operands and then runs its bit cycles, in order the
// positions, the scaled differences and the magnitudes; last the output
// register is filled and m_axis_tvalid rises. A history-only sample frees
// the input after the position phases. One item at a time: the next sample
// is accepted only once the result has entered the output register, and
// s_axis_tready rises in the same cycle as m_axis_tvalid.
// Reset clears the history, the fill count, the sequencer and the output valid
// and sets the APB registers to their reset values. While the receiver holds
// m_axis_tready low the result waits in the output register; the next sample
// is still accepted and worked on, then held until the output register is free.
// Configuration: APB, four 32-bit registers at byte addresses 0,4,8,12.
module track_speed_accel_estimator #(
    parameter int INPUT_FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // x_norm[15:0], y_norm[31:16]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata    // vel_x, vel_y, speed, acc_x, acc_y, acc_mag, pad
);
    localparam int F = INPUT_FRAC_BITS;
    // position multiplier: 16-bit norm times 18-bit length, serial over length
    localparam int PW = 2 * 16 + 2 * 18 + F + 4;

    logic [17:0] plen_reg, pwid_reg;
    logic [23:0] itdt_reg;
    logic [27:0] idsq_reg;

    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[3:2])
            tsae_pkg::REG_PITCH_LEN:  prdata = {14'd0, plen_reg};
            tsae_pkg::REG_PITCH_WID:  prdata = {14'd0, pwid_reg};
            tsae_pkg::REG_INV_TWO_DT: prdata = {8'd0, itdt_reg};
            default:                  prdata = {4'd0, idsq_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg <= tsae_pkg::PITCH_LEN_RST;
            pwid_reg <= tsae_pkg::PITCH_WID_RST;
            itdt_reg <= tsae_pkg::INV_TWO_DT_RST;
            idsq_reg <= tsae_pkg::INV_DT_SQ_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                tsae_pkg::REG_PITCH_LEN:  plen_reg <= pwdata[17:0];
                tsae_pkg::REG_PITCH_WID:  pwid_reg <= pwdata[17:0];
                tsae_pkg::REG_INV_TWO_DT: itdt_reg <= pwdata[23:0];
                default:                  idsq_reg <= pwdata[27:0];
            endcase
        end
    end

    tsae_pkg::state_t state_reg, state_next;
    logic [1:0]  fill_reg;
    logic [15:0] xin_reg, yin_reg;
    logic signed [17:0] x0_reg, x1_reg, y0_reg, y1_reg, xn_reg, yn_reg;
    logic signed [20:0] vx_reg, vy_reg;
    logic [20:0] spd_reg;
    logic signed [24:0] ax_reg, ay_reg;
    logic [24:0] amag_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;          // current phase has been loaded

    // serial multiplier: acc += mcand when multiplier lsb set, mcand <<= 1
    logic signed [PW-1:0] acc_reg, mcand_reg;
    logic [27:0] mplier_reg;
    // isqrt state
    logic [51:0] rad_reg;
    logic [25:0] root_reg;
    logic [27:0] rem_reg;

    logic        out_v_reg;
    logic [143:0] out_d_reg;

    assign s_axis_tready = (state_reg == tsae_pkg::ST_IDLE);
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_d_reg;

    // operand selection for the multiply phases
    logic signed [PW-1:0] ld_mcand;
    logic [27:0] ld_mplier;
    logic [5:0]  ld_cnt;
    logic signed [PW-1:0] ld_acc;
    always_comb begin
        ld_mcand = '0; ld_mplier = '0; ld_cnt = 6'(tsae_pkg::MUL_CYC); ld_acc = '0;
        unique case (state_reg)
            tsae_pkg::ST_POSX: begin
                ld_mcand  = PW'(2 * 32'(xin_reg)) ;
                ld_mplier = 28'(plen_reg);
                ld_cnt    = 6'd18;
                ld_acc    = PW'(1) <<< F;
                ld_acc    = ld_acc - (PW'(plen_reg) <<< F);
            end
            tsae_pkg::ST_POSY: begin
                ld_mcand  = PW'(2 * 32'(yin_reg));
                ld_mplier = 28'(pwid_reg);
                ld_cnt    = 6'd18;
                ld_acc    = PW'(1) <<< F;
                ld_acc    = ld_acc - (PW'(pwid_reg) <<< F);
            end
            tsae_pkg::ST_VX: begin
                ld_mcand  = PW'(signed'({xn_reg[17], xn_reg}) - signed'({x0_reg[17], x0_reg}));
                ld_mplier = 28'(itdt_reg);
                ld_acc    = PW'(32768);
            end
            tsae_pkg::ST_VY: begin
                ld_mcand  = PW'(signed'({yn_reg[17], yn_reg}) - signed'({y0_reg[17], y0_reg}));
                ld_mplier = 28'(itdt_reg);
                ld_acc    = PW'(32768);
            end
            tsae_pkg::ST_AX: begin
                ld_mcand  = PW'(signed'({{2{xn_reg[17]}}, xn_reg})
                          - signed'({x1_reg[17], x1_reg, 1'b0})
                          + signed'({{2{x0_reg[17]}}, x0_reg}));
                ld_mplier = idsq_reg;
                ld_acc    = PW'(32768);
            end
            tsae_pkg::ST_AY: begin
                ld_mcand  = PW'(signed'({{2{yn_reg[17]}}, yn_reg})
                          - signed'({y1_reg[17], y1_reg, 1'b0})
                          + signed'({{2{y0_reg[17]}}, y0_reg}));
                ld_mplier = idsq_reg;
                ld_acc    = PW'(32768);
            end
            default: ;
        endcase
    end

    // squares for the magnitude phases, formed once at load
    logic signed [24:0] sq_opa, sq_opb;
    logic signed [49:0] sq_a, sq_b;
    logic [51:0] ld_rad;
    always_comb begin
        if (state_reg == tsae_pkg::ST_SPD) begin
            sq_opa = 25'(vx_reg);
            sq_opb = 25'(vy_reg);
        end else begin
            sq_opa = ax_reg;
            sq_opb = ay_reg;
        end
        sq_a   = sq_opa * sq_opa;
        sq_b   = sq_opb * sq_opb;
        ld_rad = 52'(sq_a) + 52'(sq_b);
    end

    logic [27:0] trial;
    logic [27:0] rem_sh;
    always_comb begin
        rem_sh = {rem_reg[25:0], rad_reg[51:50]};
        trial  = {root_reg, 2'b01};
    end

    logic is_mul, is_sqrt, last;
    always_comb begin
        is_mul  = state_reg inside {tsae_pkg::ST_POSX, tsae_pkg::ST_POSY, tsae_pkg::ST_VX,
                                    tsae_pkg::ST_VY, tsae_pkg::ST_AX, tsae_pkg::ST_AY};
        is_sqrt = state_reg == tsae_pkg::ST_SPD || state_reg == tsae_pkg::ST_AMAG;
        last    = busy_reg && cnt_reg == 6'd0;
    end

    // final products include the last multiplier bit
    logic signed [PW-1:0] fin;
    logic signed [17:0] pos_y_fin;
    logic signed [PW-1:0] finp;
    always_comb begin
        fin  = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;
        finp = fin >>> (F + 1);
        if (finp > PW'(131071))       pos_y_fin = 18'sd131071;
        else if (finp < -PW'(131072)) pos_y_fin = -18'sd131072;
        else                          pos_y_fin = finp[17:0];
    end

    logic signed [PW-1:0] finv;
    logic signed [20:0] vfin;
    logic signed [24:0] afin;
    always_comb begin
        finv = fin >>> 16;
        if (finv > PW'(1048575))       vfin = 21'sd1048575;
        else if (finv < -PW'(1048575)) vfin = -21'sd1048575;
        else                           vfin = finv[20:0];
        if (finv > PW'(16777215))      afin = 25'sd16777215;
        else if (finv < -PW'(16777215)) afin = -25'sd16777215;
        else                           afin = finv[24:0];
    end

    logic [25:0] root_fin;
    assign root_fin = {root_reg[24:0], (rem_sh >= trial)};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tsae_pkg::ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_next = tsae_pkg::ST_POSX;
            tsae_pkg::ST_POSX: if (last) state_next = tsae_pkg::ST_POSY;
            tsae_pkg::ST_POSY: if (last)
                state_next = (fill_reg == 2'd2) ? tsae_pkg::ST_VX : tsae_pkg::ST_IDLE;
            tsae_pkg::ST_VX:   if (last) state_next = tsae_pkg::ST_VY;
            tsae_pkg::ST_VY:   if (last) state_next = tsae_pkg::ST_AX;
            tsae_pkg::ST_AX:   if (last) state_next = tsae_pkg::ST_AY;
            tsae_pkg::ST_AY:   if (last) state_next = tsae_pkg::ST_SPD;
            tsae_pkg::ST_SPD:  if (last) state_next = tsae_pkg::ST_AMAG;
            tsae_pkg::ST_AMAG: if (last) state_next = tsae_pkg::ST_OUT;
            tsae_pkg::ST_OUT:  if (!out_v_reg) state_next = tsae_pkg::ST_IDLE;
            default:           state_next = tsae_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tsae_pkg::ST_IDLE;
            fill_reg  <= 2'd0;
            busy_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            x0_reg <= '0; x1_reg <= '0; y0_reg <= '0; y1_reg <= '0;
        end else begin
            state_reg <= state_next;
            // output register refills only once the previous result is gone
            if (state_reg == tsae_pkg::ST_OUT && !out_v_reg) out_v_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)        out_v_reg <= 1'b0;
            if (state_reg == tsae_pkg::ST_IDLE && s_axis_tvalid && s_axis_tready) begin
                xin_reg <= s_axis_tdata[15:0];
                yin_reg <= s_axis_tdata[31:16];
            end
            if ((is_mul || is_sqrt) && !busy_reg) begin
                busy_reg <= 1'b1;
                if (is_mul) begin
                    acc_reg    <= ld_acc;
                    mcand_reg  <= ld_mcand;
                    mplier_reg <= ld_mplier;
                    cnt_reg    <= ld_cnt - 6'd1;
                end else begin
                    rad_reg  <= ld_rad;
                    root_reg <= '0;
                    rem_reg  <= '0;
                    cnt_reg  <= 6'(tsae_pkg::SQRT_CYC - 1);
                end
            end else if (busy_reg && is_mul) begin
                if (mplier_reg[0]) acc_reg <= acc_reg + mcand_reg;
                mcand_reg  <= mcand_reg <<< 1;
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg - 6'd1;
                if (last) busy_reg <= 1'b0;
            end else if (busy_reg && is_sqrt) begin
                rad_reg <= rad_reg << 2;
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[24:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[24:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (last) busy_reg <= 1'b0;
            end
            if (state_reg == tsae_pkg::ST_POSY && last && fill_reg != 2'd2) begin
                x0_reg <= x1_reg; y0_reg <= y1_reg;
                x1_reg <= xn_reg; y1_reg <= pos_y_fin;
                fill_reg <= fill_reg + 2'd1;
            end
            if (state_reg == tsae_pkg::ST_AMAG && last) begin
                x0_reg <= x1_reg; y0_reg <= y1_reg;
                x1_reg <= xn_reg; y1_reg <= yn_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (last) begin
            unique case (state_reg)
                tsae_pkg::ST_POSX: xn_reg <= pos_y_fin;
                tsae_pkg::ST_POSY: yn_reg <= pos_y_fin;
                tsae_pkg::ST_VX:   vx_reg <= vfin;
                tsae_pkg::ST_VY:   vy_reg <= vfin;
                tsae_pkg::ST_AX:   ax_reg <= afin;
                tsae_pkg::ST_AY:   ay_reg <= afin;
                tsae_pkg::ST_SPD:  spd_reg <= root_fin[20:0];
                tsae_pkg::ST_AMAG: amag_reg <= root_fin[24:0];
                default: ;
            endcase
        end
        if (state_reg == tsae_pkg::ST_OUT && !out_v_reg)
            out_d_reg <= {6'd0, amag_reg, ay_reg, ax_reg, spd_reg, vy_reg, vx_reg};
    end
endmodule
